### rtl/jdconv_pkg.sv
// ----------------------------------------------------------------------------
// jdconv_pkg: shared types and constants for the Julian day converter
// Request and result transaction layouts, operation codes, year window and
// the fixed-point constants used by the converter datapath.
// ----------------------------------------------------------------------------
package jdconv_pkg;

  localparam int FRACTION_BITS = 32;
  localparam int FRAC_KEEP     = (FRACTION_BITS < 32) ? FRACTION_BITS : 32;
  localparam logic [31:0] FRAC_MASK =
    (FRAC_KEEP >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << FRAC_KEEP) - 64'd1);

  localparam logic OP_TO_JD  = 1'b0;
  localparam logic OP_TO_DOY = 1'b1;

  localparam logic [11:0] YEAR_LO    = 12'd1901;
  localparam logic [11:0] YEAR_HI    = 12'd2099;
  localparam logic [11:0] YY_PIVOT   = 12'd80;
  localparam logic [11:0] CENTURY_19 = 12'd1900;
  localparam logic [11:0] CENTURY_20 = 12'd2000;

  localparam logic [16:0] HALF_DAY     = 17'd43200;
  localparam logic [17:0] FULL_DAY     = 18'd86400;
  localparam logic [17:0] TWO_DAYS     = 18'd172800;

  // Julian day of 1 Jan 1901 (noon based) and of 31 Dec 2099
  localparam logic [22:0] JD_FIRST  = 23'd2415386;
  localparam logic [22:0] JD_LAST   = 23'd2488069;
  // day number preceding 1 Jan 1901, less one for the 1-based day of year
  localparam logic [22:0] JAN1_BASE = 23'd2415384;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

  // (4z+3)/1461 as a multiply by reciprocal, exact for z within the year window
  localparam int          RECIP_SHIFT = 30;
  localparam logic [19:0] RECIP       = 20'd734937;

  typedef struct packed {
    logic        op;
    logic [11:0] in_year;
    logic [21:0] in_day;
    logic [16:0] in_seconds;
    logic [31:0] in_fraction;
  } req_t;

  typedef struct packed {
    logic [11:0] out_year;
    logic [21:0] out_day;
    logic [16:0] out_seconds;
    logic [31:0] out_fraction;
    logic        range_error;
  } res_t;

endpackage

### rtl/julian_day_doy_converter_core.sv
// ----------------------------------------------------------------------------
// julian_day_doy_converter_core: GNSS day-of-year / Julian day converter
// Takes one request transaction per cycle and returns one result transaction
// for each, in order.
// ----------------------------------------------------------------------------
// A request is taken on every cycle in which start is high; busy stays low, so
// a new transaction may follow in the next cycle. Each result appears on result
// with done high for exactly one cycle, after its request has passed the input
// register, the year/day normalisation stage with the reciprocal multiply and
// the day-number stage. The receiver cannot stall the block and must
// take every result in the cycle it is shown.
module julian_day_doy_converter_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  jdconv_pkg::req_t  request,
  output logic              done,
  output jdconv_pkg::res_t  result
);

  jdconv_pkg::req_t req;
  logic             req_vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start && !busy;
    end
    req <= request;
  end

  jdconv_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .req_vld (req_vld),
    .req     (req),
    .res_vld (done),
    .res     (result)
  );

endmodule

### rtl/jdconv_datapath.sv
// ----------------------------------------------------------------------------
// jdconv_datapath: two-stage conversion datapath
// Stage one normalises seconds, maps the year or Julian day into the window
// and forms the year-index product; stage two builds the day number and the
// result transaction.
// ----------------------------------------------------------------------------
module jdconv_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_vld,
  input  jdconv_pkg::req_t  req,
  output logic              res_vld,
  output jdconv_pkg::res_t  res
);

  typedef struct packed {
    logic        op;
    logic        err;
    logic [7:0]  k_year;
    logic [7:0]  k_jd;
    logic [22:0] base;
    logic [16:0] z;
    logic [16:0] seconds;
    logic [31:0] fraction;
  } mid_t;

  mid_t        mid;
  mid_t        mid_next;
  logic        mid_vld;

  logic [11:0] y;
  logic        err0;
  logic [17:0] t;
  logic [1:0]  qt;
  logic [16:0] os0;
  logic        wrap;
  logic [16:0] s;
  logic        pm;
  logic [22:0] a;
  logic        err1;
  logic [16:0] z;
  logic [16:0] os1;
  logic [38:0] prod;

  always_comb begin
    if (req.in_year < jdconv_pkg::CENTURY_19) begin
      y = req.in_year + ((req.in_year < jdconv_pkg::YY_PIVOT) ?
                         jdconv_pkg::CENTURY_20 : jdconv_pkg::CENTURY_19);
    end else begin
      y = req.in_year;
    end
    err0 = (y < jdconv_pkg::YEAR_LO) || (y > jdconv_pkg::YEAR_HI);

    t = {1'b0, jdconv_pkg::HALF_DAY} + {1'b0, req.in_seconds};
    if (t >= jdconv_pkg::TWO_DAYS) begin
      qt  = 2'd2;
      os0 = 17'(t - jdconv_pkg::TWO_DAYS);
    end else if (t >= jdconv_pkg::FULL_DAY) begin
      qt  = 2'd1;
      os0 = 17'(t - jdconv_pkg::FULL_DAY);
    end else begin
      qt  = 2'd0;
      os0 = t[16:0];
    end

    wrap = ({1'b0, req.in_seconds} >= jdconv_pkg::FULL_DAY);
    s    = wrap ? 17'({1'b0, req.in_seconds} - jdconv_pkg::FULL_DAY) : req.in_seconds;
    pm   = (s >= jdconv_pkg::HALF_DAY);
    a    = {1'b0, req.in_day} + {22'd0, wrap} + {22'd0, pm};
    err1 = (a < jdconv_pkg::JD_FIRST) || (a > jdconv_pkg::JD_LAST);
    z    = 17'(a - jdconv_pkg::JD_FIRST);
    os1  = pm ? (s - jdconv_pkg::HALF_DAY) : (s + jdconv_pkg::HALF_DAY);
    prod = 39'({z, 2'b11}) * 39'(jdconv_pkg::RECIP);

    mid_next.op       = req.op;
    mid_next.err      = (req.op == jdconv_pkg::OP_TO_DOY) ? err1 : err0;
    mid_next.k_year   = 8'(y - jdconv_pkg::YEAR_LO);
    mid_next.k_jd     = prod[jdconv_pkg::RECIP_SHIFT +: 8];
    mid_next.base     = jdconv_pkg::JAN1_BASE + {1'b0, req.in_day} + {21'd0, qt};
    mid_next.z        = z;
    mid_next.seconds  = (req.op == jdconv_pkg::OP_TO_DOY) ? os1 : os0;
    mid_next.fraction = req.in_fraction & jdconv_pkg::FRAC_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
    end else begin
      mid_vld <= req_vld;
    end
    mid <= mid_next;
  end

  logic [7:0]       k;
  logic [16:0]      off;
  jdconv_pkg::res_t res_next;

  always_comb begin
    k   = (mid.op == jdconv_pkg::OP_TO_DOY) ? mid.k_jd : mid.k_year;
    off = 17'({9'd0, k} * 17'(jdconv_pkg::DAYS_PER_YEAR)) + {11'd0, k[7:2]};

    res_next.out_fraction = mid.fraction;
    res_next.range_error  = mid.err;
    if (mid.err) begin
      res_next.out_year    = '0;
      res_next.out_day     = '0;
      res_next.out_seconds = '0;
    end else if (mid.op == jdconv_pkg::OP_TO_DOY) begin
      res_next.out_year    = jdconv_pkg::YEAR_LO + {4'd0, k};
      res_next.out_day     = {5'd0, 17'(mid.z + 17'd1 - off)};
      res_next.out_seconds = mid.seconds;
    end else begin
      res_next.out_year    = '0;
      res_next.out_day     = 22'(mid.base + {6'd0, off});
      res_next.out_seconds = mid.seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else begin
      res_vld <= mid_vld;
    end
    res <= res_next;
  end

endmodule

### rtl/jdconv_checker.sv
// ----------------------------------------------------------------------------
// jdconv_checker: port-level checks for the converter
// Latency, ordering and result-shape properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module jdconv_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input jdconv_pkg::res_t result,
  input logic             done
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("transaction result missing");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without request");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    (done && result.range_error) |->
      (result.out_year == 12'd0 && result.out_day == 22'd0 &&
       result.out_seconds == 17'd0))
    else $error("range error with non-zero fields");

  a_doy_shape: assert property (@(posedge clk) disable iff (rst)
    (done && !result.range_error && result.out_year != 12'd0) |->
      (result.out_year >= jdconv_pkg::YEAR_LO && result.out_year <= jdconv_pkg::YEAR_HI &&
       result.out_day >= 22'd1 && result.out_day <= 22'd366 &&
       result.out_seconds < 17'd86400))
    else $error("day-of-year result out of shape");

endmodule

bind julian_day_doy_converter_core jdconv_checker u_jdconv_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .done   (done)
);

### verif/julian_day_doy_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_day_doy_converter_core_tb: self-checking bench for the JD converter
// Drives a directed table of time stamps, then several hundred random ones in
// both directions. Random idle bursts and full drains sit between requests.
// Every result is compared with the expected year, day, seconds, fraction and
// range flag: typed table rows give them, else an in-bench calculation does.
// ----------------------------------------------------------------------------
module julian_day_doy_converter_core_tb;

  localparam longint SEC_HALF_DAY = 43200;
  localparam longint SEC_PER_DAY  = 86400;
  localparam longint JAN1_OFS     = 1721410;
  localparam int     RANDOM_STAMPS = 450;

  typedef struct {
    jdconv_pkg::req_t rq;
    bit               typed;
    jdconv_pkg::res_t res;
  } stamp_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  jdconv_pkg::req_t request;
  jdconv_pkg::res_t result;

  jdconv_pkg::res_t pending_stamps[$];
  stamp_row_t       directed_rows[$];
  int               mismatch_count;
  int               results_checked;
  int               n_to_jd;
  int               n_to_doy;
  int               n_flagged;
  bit               quiet;

  julian_day_doy_converter_core u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint jan1_jd(longint yr);
    return (1461 * (yr - 1)) / 4 + JAN1_OFS;
  endfunction

  // integer calendar year of a Julian day number
  function automatic longint civil_year_of_jd(longint jd);
    longint l;
    longint n;
    longint i;
    longint j;
    l = jd + 68569;
    n = (4 * l) / 146097;
    l = l - (146097 * n + 3) / 4;
    i = (4000 * (l + 1)) / 1461001;
    l = l - (1461 * i) / 4 + 31;
    j = (80 * l) / 2447;
    return 100 * (n - 49) + i + j / 11;
  endfunction

  function automatic jdconv_pkg::res_t convert_stamp(jdconv_pkg::req_t rq);
    jdconv_pkg::res_t r;
    longint yr;
    longint jd;
    longint secs;
    longint tod;
    bit     pm;
    r = '0;
    r.out_fraction = rq.in_fraction & jdconv_pkg::FRAC_MASK;
    if (rq.op == jdconv_pkg::OP_TO_JD) begin
      yr = longint'(rq.in_year);
      if (yr < longint'(jdconv_pkg::CENTURY_19)) begin
        yr = yr + ((yr < longint'(jdconv_pkg::YY_PIVOT)) ?
                   longint'(jdconv_pkg::CENTURY_20) : longint'(jdconv_pkg::CENTURY_19));
      end
      if (yr < longint'(jdconv_pkg::YEAR_LO) || yr > longint'(jdconv_pkg::YEAR_HI)) begin
        r.range_error = 1'b1;
      end else begin
        tod = SEC_HALF_DAY + longint'(rq.in_seconds);
        jd = jan1_jd(yr) + longint'(rq.in_day) - 1 + tod / SEC_PER_DAY;
        r.out_day = jd[21:0];
        secs = tod % SEC_PER_DAY;
        r.out_seconds = secs[16:0];
      end
    end else begin
      jd = longint'(rq.in_day) + longint'(rq.in_seconds) / SEC_PER_DAY;
      secs = longint'(rq.in_seconds) % SEC_PER_DAY;
      pm = (secs >= SEC_HALF_DAY);
      if (pm) begin
        jd = jd + 1;
      end
      yr = civil_year_of_jd(jd);
      if (yr < longint'(jdconv_pkg::YEAR_LO) || yr > longint'(jdconv_pkg::YEAR_HI)) begin
        r.range_error = 1'b1;
      end else begin
        r.out_year = yr[11:0];
        jd = jd - jan1_jd(yr);
        r.out_day = jd[21:0];
        secs = pm ? (secs - SEC_HALF_DAY) : (secs + SEC_HALF_DAY);
        r.out_seconds = secs[16:0];
      end
    end
    return r;
  endfunction

  function automatic jdconv_pkg::req_t random_stamp();
    jdconv_pkg::req_t rq;
    int               pick;
    rq.op = 1'($urandom_range(0, 1));
    rq.in_fraction = $urandom;
    rq.in_year = 12'($urandom_range(0, 4095));
    pick = $urandom_range(0, 9);
    if (rq.op == jdconv_pkg::OP_TO_JD) begin
      case ($urandom_range(0, 2))
        0: begin
          rq.in_year = 12'($urandom_range(1901, 2099));
        end
        1: begin
          rq.in_year = 12'($urandom_range(0, 99));
        end
        default: begin
          rq.in_year = 12'($urandom_range(1895, 2105));
        end
      endcase
      rq.in_day = 22'($urandom_range(1, 366));
      rq.in_seconds = 17'($urandom_range(0, 86399));
      if (pick == 7) begin
        rq.in_year = 12'($urandom_range(0, 4095));
      end else if (pick == 8) begin
        rq.in_day = 22'($urandom_range(0, 4194303));
      end else if (pick == 9) begin
        rq.in_seconds = 17'($urandom_range(0, 131071));
      end
    end else begin
      rq.in_day = 22'($urandom_range(2415380, 2488075));
      rq.in_seconds = 17'($urandom_range(0, 86399));
      if (pick == 8) begin
        rq.in_day = 22'($urandom_range(0, 4194303));
      end else if (pick == 9) begin
        rq.in_seconds = 17'($urandom_range(0, 131071));
      end
    end
    return rq;
  endfunction

  task automatic add_row(bit op, int yr, int dy, int sc, bit [31:0] fr, bit typed,
                         int ey, int ed, int es, bit ee);
    stamp_row_t row;
    row.rq.op = op;
    row.rq.in_year = 12'(yr);
    row.rq.in_day = 22'(dy);
    row.rq.in_seconds = 17'(sc);
    row.rq.in_fraction = fr;
    row.typed = typed;
    row.res.out_year = 12'(ey);
    row.res.out_day = 22'(ed);
    row.res.out_seconds = 17'(es);
    row.res.out_fraction = fr & jdconv_pkg::FRAC_MASK;
    row.res.range_error = ee;
    directed_rows.push_back(row);
  endtask

  // hold start until the block takes the transaction, then log what is owed
  task automatic issue_stamp(jdconv_pkg::req_t rq, bit typed, jdconv_pkg::res_t typed_res);
    jdconv_pkg::res_t want;
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = typed ? typed_res : convert_stamp(rq);
    pending_stamps.push_back(want);
    if (rq.op == jdconv_pkg::OP_TO_JD) n_to_jd++;
    else n_to_doy++;
    if (want.range_error) n_flagged++;
  endtask

  task automatic maybe_pause(int idx);
    if (idx % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    jdconv_pkg::res_t want;
    if (!rst && done) begin
      if (pending_stamps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] unexpected result transaction %p", $time, result);
        end
      end else begin
        want = pending_stamps.pop_front();
        results_checked++;
        if (result.out_year !== want.out_year || result.out_day !== want.out_day ||
            result.out_seconds !== want.out_seconds ||
            result.out_fraction !== want.out_fraction ||
            result.range_error !== want.range_error) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: year %0d/%0d day %0d/%0d sec %0d/%0d frac %h/%h err %b/%b",
                     $time, result.out_year, want.out_year, result.out_day, want.out_day,
                     result.out_seconds, want.out_seconds, result.out_fraction,
                     want.out_fraction, result.range_error, want.range_error);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("julian_day_doy_converter_core_tb: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    mismatch_count = 0;
    results_checked = 0;
    n_to_jd = 0;
    n_to_doy = 0;
    n_flagged = 0;
    quiet = 1'b0;

    // op, year, day, seconds, fraction, typed, exp year, exp day, exp sec, exp flag
    add_row(jdconv_pkg::OP_TO_JD,  1901, 1, 0, 32'h0000_0000, 1, 0, 2415385, 43200, 0);
    add_row(jdconv_pkg::OP_TO_JD,  0, 1, 0, 32'hFFFF_FFFF, 1, 0, 2451544, 43200, 0);
    add_row(jdconv_pkg::OP_TO_JD,  79, 366, 86399, 32'h8000_0001, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_JD,  80, 1, 43200, 32'h1234_5678, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_JD,  99, 365, 0, 32'hA5A5_A5A5, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_JD,  1900, 1, 0, 32'h5A5A_5A5A, 1, 0, 0, 0, 1);
    add_row(jdconv_pkg::OP_TO_JD,  2099, 365, 86399, 32'h0000_0001, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_JD,  2100, 1, 0, 32'hDEAD_BEEF, 1, 0, 0, 0, 1);
    add_row(jdconv_pkg::OP_TO_JD,  4095, 4194303, 131071, 32'hFFFF_FFFF, 1, 0, 0, 0, 1);
    add_row(jdconv_pkg::OP_TO_JD,  2024, 0, 0, 32'h0F0F_0F0F, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_JD,  2024, 4194303, 43199, 32'hF0F0_F0F0, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_JD,  2000, 60, 131071, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_DOY, 0, 0, 0, 32'h0000_0000, 1, 0, 0, 0, 1);
    add_row(jdconv_pkg::OP_TO_DOY, 4095, 4194303, 131071, 32'hFFFF_FFFF, 1, 0, 0, 0, 1);
    add_row(jdconv_pkg::OP_TO_DOY, 0, 2451544, 43200, 32'hCAFE_F00D, 1, 2000, 1, 0, 0);
    add_row(jdconv_pkg::OP_TO_DOY, 0, 2451544, 43199, 32'h0000_FFFF, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_DOY, 0, 2415385, 43200, 32'hFFFF_0000, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_DOY, 0, 2415384, 0, 32'h1111_1111, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_DOY, 0, 2488069, 86399, 32'h2222_2222, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_DOY, 0, 2488070, 43200, 32'h4444_4444, 0, 0, 0, 0, 0);
    add_row(jdconv_pkg::OP_TO_DOY, 2099, 2451544, 131071, 32'h8888_8888, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      issue_stamp(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].res);
      maybe_pause(k + 1);
    end

    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      issue_stamp(random_stamp(), 1'b0, '0);
      if (i == 150 || i == 320) drain();
      else if (i < RANDOM_STAMPS - 60) maybe_pause(i);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d day-of-year to JD and %0d JD to day-of-year transactions",
             n_to_jd, n_to_doy);
    $display("%0d expected a range flag; %0d results checked, %0d mismatches",
             n_flagged, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("julian_day_doy_converter_core_tb: PASS");
    end else begin
      $display("julian_day_doy_converter_core_tb: FAIL");
    end
    $finish;
  end

endmodule
